// ----- hw/rtl/fpd_pkg.sv -----
// Shared constants, rule table and register codes of the fuzzy PD controller.
`default_nettype none

package fpd_pkg;

  localparam int DATA_W     = 16;
  localparam int W_FRAC     = 12;
  localparam int W_W        = W_FRAC + 1;
  localparam int LEVEL_W    = 3;
  localparam int ROM_DIM    = 7;
  localparam int ROM_LAST   = ROM_DIM - 1;
  localparam int NUM_LEVELS_DEF = 7;

  localparam logic [W_W-1:0] W_ONE = W_W'(1 << W_FRAC);

  // Register index codes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_INV_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERR_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERR_INV_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEP      = 3'd5;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_ERR_MIN       = 16'hE200; // -7680
  localparam logic [DATA_W-1:0] RST_ERR_INV_STEP  = 16'd410;
  localparam logic [DATA_W-1:0] RST_DERR_MIN      = 16'hF400; // -3072
  localparam logic [DATA_W-1:0] RST_DERR_INV_STEP = 16'd1024;
  localparam logic [DATA_W-1:0] RST_OUT_MIN       = 16'hD99A; // -9830
  localparam logic [DATA_W-1:0] RST_OUT_STEP      = 16'd3959;

  // Rule levels, row = derivative set, column = error set (0=NB .. 6=PB)
  localparam logic [LEVEL_W-1:0] RULE_ROM [0:ROM_DIM*ROM_DIM-1] = '{
    3'd2, 3'd3, 3'd3, 3'd3, 3'd5, 3'd6, 3'd6,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5,
    3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd5, 3'd4,
    3'd6, 3'd6, 3'd6, 3'd3, 3'd5, 3'd6, 3'd4
  };

  function automatic logic [LEVEL_W-1:0] rule_level(logic [2:0] row, logic [2:0] col);
    logic [5:0] addr;
    addr = 6'(row) * 6'(ROM_DIM) + 6'(col);
    return RULE_ROM[addr];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpd_fuzzify.sv -----
// Three-stage fuzzifier: offset, scale to set position, split into index and weights.
`default_nettype none

module fpd_fuzzify #(
  parameter int NUM_LEVELS = fpd_pkg::NUM_LEVELS_DEF,
  parameter int IDX_W      = $clog2(NUM_LEVELS)
) (
  input  wire logic                        clk,
  input  wire logic [2:0]                  adv,
  input  wire logic signed [fpd_pkg::DATA_W-1:0] x,
  input  wire logic signed [fpd_pkg::DATA_W-1:0] mn,
  input  wire logic [fpd_pkg::DATA_W-1:0]  inv,
  output logic [IDX_W-1:0]                 idx,
  output logic [fpd_pkg::W_W-1:0]          w_lo,
  output logic [fpd_pkg::W_W-1:0]          w_hi
);

  localparam int DIFF_W = fpd_pkg::DATA_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int POS_W  = 2 * fpd_pkg::DATA_W - 8;
  localparam logic [POS_W-1:0] TOP = POS_W'((NUM_LEVELS - 1) << fpd_pkg::W_FRAC);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [POS_W-1:0]         pos;

  assign pos = prod[POS_W+7:8];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      diff <= DIFF_W'(x) - DIFF_W'(mn);
    end
    if (adv[1]) begin
      prod <= diff * $signed({1'b0, inv});
    end
    if (adv[2]) begin
      priority if (prod[PROD_W-1]) begin
        idx  <= '0;
        w_lo <= fpd_pkg::W_ONE;
        w_hi <= '0;
      end else if (pos >= TOP) begin
        idx  <= IDX_W'(NUM_LEVELS - 2);
        w_lo <= '0;
        w_hi <= fpd_pkg::W_ONE;
      end else begin
        idx  <= pos[fpd_pkg::W_FRAC +: IDX_W];
        w_hi <= {1'b0, pos[fpd_pkg::W_FRAC-1:0]};
        w_lo <= fpd_pkg::W_ONE - {1'b0, pos[fpd_pkg::W_FRAC-1:0]};
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fuzzy_pd_controller.sv -----
// Top level of the pipelined two-input fuzzy PD controller.
//
//   channel   direction  handshake               payload
//   in        request    in_valid / in_ready     err, derr (signed Q7.8)
//   out       result     out_valid / out_ready   drive (signed Q4.12, saturated)
//   cfg       write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Eight register stages; a request enters every cycle when nothing stalls.
// The two 17x17 position multipliers and the 20x26 term multipliers each
// get a stage of their own.
// Reset clears every stage valid bit, loads the register defaults and holds
// both ready signals low.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stalled output does not block an empty pipeline.
// The config port is ready whenever reset is low; write registers only while idle.
`default_nettype none

module fuzzy_pd_controller #(
  parameter int NUM_LEVELS = fpd_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [fpd_pkg::DATA_W-1:0]   err,
  input  wire logic signed [fpd_pkg::DATA_W-1:0]   derr,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [fpd_pkg::DATA_W-1:0]        drive,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [fpd_pkg::DATA_W-1:0]          cfg_data
);

  localparam int IDX_W   = $clog2(NUM_LEVELS);
  localparam int EXT_W   = (IDX_W > 3) ? IDX_W : 3;
  localparam int NSTAGE  = 8;
  localparam int WP_W    = 2 * fpd_pkg::W_W - 1;    // product of two weights
  localparam int VAL_W   = fpd_pkg::DATA_W + 4;     // out_min + level*out_step
  localparam int TERM_W  = VAL_W + WP_W + 1;
  localparam int SUM_W   = TERM_W + 1;
  localparam int SH      = 2 * fpd_pkg::W_FRAC;
  localparam int RES_W   = SUM_W - SH;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (SH - 1);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(32768);

  // Configuration registers
  logic signed [fpd_pkg::DATA_W-1:0] err_min;
  logic [fpd_pkg::DATA_W-1:0]        err_inv_step;
  logic signed [fpd_pkg::DATA_W-1:0] derr_min;
  logic [fpd_pkg::DATA_W-1:0]        derr_inv_step;
  logic signed [fpd_pkg::DATA_W-1:0] out_min;
  logic signed [fpd_pkg::DATA_W-1:0] out_step;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_min       <= fpd_pkg::RST_ERR_MIN;
      err_inv_step  <= fpd_pkg::RST_ERR_INV_STEP;
      derr_min      <= fpd_pkg::RST_DERR_MIN;
      derr_inv_step <= fpd_pkg::RST_DERR_INV_STEP;
      out_min       <= fpd_pkg::RST_OUT_MIN;
      out_step      <= fpd_pkg::RST_OUT_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpd_pkg::CFG_ERR_MIN:       err_min       <= cfg_data;
        fpd_pkg::CFG_ERR_INV_STEP:  err_inv_step  <= cfg_data;
        fpd_pkg::CFG_DERR_MIN:      derr_min      <= cfg_data;
        fpd_pkg::CFG_DERR_INV_STEP: derr_inv_step <= cfg_data;
        fpd_pkg::CFG_OUT_MIN:       out_min       <= cfg_data;
        fpd_pkg::CFG_OUT_STEP:      out_step      <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Stage valid bits and advance enables; stage s uses bit s-1.
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0] && !rst;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stages 1-3: fuzzify both inputs
  logic [IDX_W-1:0]          e_idx, d_idx;
  logic [fpd_pkg::W_W-1:0]   ew_lo, ew_hi, dw_lo, dw_hi;

  fpd_fuzzify #(.NUM_LEVELS(NUM_LEVELS), .IDX_W(IDX_W)) u_fz_err (
    .clk (clk),
    .adv (adv[2:0]),
    .x   (err),
    .mn  (err_min),
    .inv (err_inv_step),
    .idx (e_idx),
    .w_lo(ew_lo),
    .w_hi(ew_hi)
  );

  fpd_fuzzify #(.NUM_LEVELS(NUM_LEVELS), .IDX_W(IDX_W)) u_fz_derr (
    .clk (clk),
    .adv (adv[2:0]),
    .x   (derr),
    .mn  (derr_min),
    .inv (derr_inv_step),
    .idx (d_idx),
    .w_lo(dw_lo),
    .w_hi(dw_hi)
  );

  // Clamp a set index onto the rule table; sets past the table read its last row or column.
  function automatic logic [2:0] rom_sat(logic [IDX_W-1:0] i);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(i);
    return (ext > EXT_W'(fpd_pkg::ROM_LAST)) ? 3'(fpd_pkg::ROM_LAST) : ext[2:0];
  endfunction

  logic [IDX_W-1:0] e_idx1, d_idx1;
  assign e_idx1 = e_idx + IDX_W'(1);
  assign d_idx1 = d_idx + IDX_W'(1);

  // Stage 4: rule lookup for the four corners and weight products.
  // Corner order: 0 = (d, e), 1 = (d, e+1), 2 = (d+1, e), 3 = (d+1, e+1).
  logic [fpd_pkg::LEVEL_W-1:0] lvl [4];
  logic [WP_W-1:0]             wp4 [4];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      lvl[0] <= fpd_pkg::rule_level(rom_sat(d_idx),  rom_sat(e_idx));
      lvl[1] <= fpd_pkg::rule_level(rom_sat(d_idx),  rom_sat(e_idx1));
      lvl[2] <= fpd_pkg::rule_level(rom_sat(d_idx1), rom_sat(e_idx));
      lvl[3] <= fpd_pkg::rule_level(rom_sat(d_idx1), rom_sat(e_idx1));
      wp4[0] <= WP_W'(dw_lo * ew_lo);
      wp4[1] <= WP_W'(dw_lo * ew_hi);
      wp4[2] <= WP_W'(dw_hi * ew_lo);
      wp4[3] <= WP_W'(dw_hi * ew_hi);
    end
  end

  // Stage 5: level values, exact
  logic signed [VAL_W-1:0] val [4];
  logic [WP_W-1:0]         wp5 [4];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int k = 0; k < 4; k++) begin
        val[k] <= VAL_W'(out_min) + VAL_W'($signed({1'b0, lvl[k]}) * out_step);
        wp5[k] <= wp4[k];
      end
    end
  end

  // Stage 6: weighted terms
  logic signed [TERM_W-1:0] term [4];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int k = 0; k < 4; k++) begin
        term[k] <= TERM_W'(val[k] * $signed({1'b0, wp5[k]}));
      end
    end
  end

  // Stage 7: pair sums
  logic signed [SUM_W-1:0] sum_a, sum_b;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      sum_a <= SUM_W'(term[0]) + SUM_W'(term[1]);
      sum_b <= SUM_W'(term[2]) + SUM_W'(term[3]);
    end
  end

  // Stage 8: final sum, round half up to Q4.12, saturate
  logic signed [SUM_W-1:0] total;
  logic signed [RES_W-1:0] res;

  assign total = sum_a + sum_b + RND;
  assign res   = RES_W'(total >>> SH);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      priority if (res > SAT_HI) begin
        drive <= fpd_pkg::DATA_W'(SAT_HI);
      end else if (res < SAT_LO) begin
        drive <= fpd_pkg::DATA_W'(SAT_LO);
      end else begin
        drive <= res[fpd_pkg::DATA_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
